### rtl/tfc_pkg.sv
// ----------------------------------------------------------------------------
// tfc_pkg
// shared types, constants and crc function for the telemetry frame checker
// ----------------------------------------------------------------------------
package tfc_pkg;

    localparam int MAX_PAYLOAD  = 256;
    localparam int HEADER_BYTES = 14;
    localparam int POS_CAP      = HEADER_BYTES + MAX_PAYLOAD;
    localparam int POS_W        = $clog2(POS_CAP + 1);
    localparam int LEN_CMP_W    = 17;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  SYNC_BYTE    = 8'hA5;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [7:0]  VERSION_INIT = 8'h01;

    localparam logic [POS_W-1:0] OFF_SYNC    = POS_W'(0);
    localparam logic [POS_W-1:0] OFF_VERSION = POS_W'(1);
    localparam logic [POS_W-1:0] OFF_TOPIC0  = POS_W'(2);
    localparam logic [POS_W-1:0] OFF_TOPIC1  = POS_W'(3);
    localparam logic [POS_W-1:0] OFF_TIME0   = POS_W'(4);
    localparam logic [POS_W-1:0] OFF_TIME1   = POS_W'(5);
    localparam logic [POS_W-1:0] OFF_TIME2   = POS_W'(6);
    localparam logic [POS_W-1:0] OFF_TIME3   = POS_W'(7);
    localparam logic [POS_W-1:0] OFF_SEQ0    = POS_W'(8);
    localparam logic [POS_W-1:0] OFF_SEQ1    = POS_W'(9);
    localparam logic [POS_W-1:0] OFF_LEN0    = POS_W'(10);
    localparam logic [POS_W-1:0] OFF_LEN1    = POS_W'(11);
    localparam logic [POS_W-1:0] OFF_CRC0    = POS_W'(12);
    localparam logic [POS_W-1:0] OFF_CRC1    = POS_W'(13);

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_MALFORMED   = 2'd1,
        STATUS_BAD_VERSION = 2'd2,
        STATUS_CRC_ERROR   = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        is_summary;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [7:0]  version_seen;
        logic [15:0] topic;
        logic [31:0] time_stamp;
        logic [15:0] seq_number;
        logic [15:0] declared_length;
        logic [15:0] carried_crc;
    } out_item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  version_seen;
        logic [15:0] topic;
        logic [31:0] time_stamp;
        logic [15:0] seq_number;
        logic [15:0] declared_length;
        logic [15:0] carried_crc;
    } summary_t;

    typedef struct packed {
        logic       has_payload;
        logic       has_summary;
        logic [7:0] payload_byte;
        summary_t   summary;
    } queue_item_t;

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### rtl/telemetry_frame_checker_top.sv
// ----------------------------------------------------------------------------
// telemetry_frame_checker_top
// a result is registered in the queue, then in the output register
// throughput: 1 byte per cycle unless the queue is full; output 1 transaction
// per cycle unless out_stall, so payload plus summary is two transactions
// reset: async active low, clears packet state, queue; expected version 1
// ----------------------------------------------------------------------------
module telemetry_frame_checker_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tfc_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output tfc_pkg::out_item_t  out_data,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data
);
    import tfc_pkg::*;

    logic        q_push;
    queue_item_t q_push_item;
    logic        q_pop;
    queue_item_t q_head;
    logic        q_full;
    logic        q_empty;

    tfc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (q_push),
        .push_item   (q_push_item),
        .q_full      (q_full)
    );

    tfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    tfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("record pushed into full queue");

    a_last_byte_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.last_byte) |=> !q_empty)
        else $error("summary record missing after last byte");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.is_summary) |->
        (out_data.status == STATUS_OK && out_data.version_seen == 8'h00
         && out_data.carried_crc == 16'h0000))
        else $error("payload transaction carries summary fields");
`endif

endmodule

### rtl/tfc_front.sv
// ----------------------------------------------------------------------------
// tfc_front
// accepts packet bytes, tracks crc and header, queues payload and summaries
// ----------------------------------------------------------------------------
module tfc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tfc_pkg::in_item_t   in_data,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    output logic                push,
    output tfc_pkg::queue_item_t push_item,
    input  logic                q_full
);
    import tfc_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next, pos_upd;
    logic [15:0]      crc_reg, crc_next, crc_upd;
    logic             sync_reg, sync_next, sync_upd;
    logic             overrun_reg, overrun_next, overrun_upd;
    logic [7:0]       ver_reg, ver_next, ver_upd;
    logic [15:0]      topic_reg, topic_next, topic_upd;
    logic [31:0]      time_reg, time_next, time_upd;
    logic [15:0]      seq_reg, seq_next, seq_upd;
    logic [15:0]      len_reg, len_next, len_upd;
    logic [15:0]      hcrc_reg, hcrc_next, hcrc_upd;
    logic [7:0]       exp_ver_reg, exp_ver_next;

    logic             accept;
    logic             at_cap;
    logic             in_payload;
    logic [7:0]       b;
    status_t          status;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign b        = in_data.byte_in;

    assign at_cap      = pos_reg >= POS_W'(POS_CAP);
    assign pos_upd     = at_cap ? pos_reg : pos_reg + POS_W'(1);
    assign overrun_upd = overrun_reg | at_cap;
    assign in_payload  = pos_reg >= POS_W'(HEADER_BYTES);
    assign crc_upd     = crc16_feed(crc_reg,
                             (pos_reg == OFF_CRC0 || pos_reg == OFF_CRC1) ? 8'h00 : b);

    // fields start at zero each packet, so each byte lane is written once
    always_comb
    begin
        sync_upd  = sync_reg;
        ver_upd   = ver_reg;
        topic_upd = topic_reg;
        time_upd  = time_reg;
        seq_upd   = seq_reg;
        len_upd   = len_reg;
        hcrc_upd  = hcrc_reg;
        unique case (pos_reg)
            OFF_SYNC:    sync_upd          = (b == SYNC_BYTE);
            OFF_VERSION: ver_upd           = b;
            OFF_TOPIC0:  topic_upd[7:0]    = b;
            OFF_TOPIC1:  topic_upd[15:8]   = b;
            OFF_TIME0:   time_upd[7:0]     = b;
            OFF_TIME1:   time_upd[15:8]    = b;
            OFF_TIME2:   time_upd[23:16]   = b;
            OFF_TIME3:   time_upd[31:24]   = b;
            OFF_SEQ0:    seq_upd[7:0]      = b;
            OFF_SEQ1:    seq_upd[15:8]     = b;
            OFF_LEN0:    len_upd[7:0]      = b;
            OFF_LEN1:    len_upd[15:8]     = b;
            OFF_CRC0:    hcrc_upd[7:0]     = b;
            OFF_CRC1:    hcrc_upd[15:8]    = b;
            default:     ;
        endcase
    end

    always_comb
    begin
        priority if (pos_upd < POS_W'(HEADER_BYTES) || !sync_upd)
            status = STATUS_MALFORMED;
        else if (ver_upd != exp_ver_reg)
            status = STATUS_BAD_VERSION;
        else if (overrun_upd
                 || LEN_CMP_W'(len_upd) > LEN_CMP_W'(MAX_PAYLOAD)
                 || LEN_CMP_W'(pos_upd) != LEN_CMP_W'(HEADER_BYTES) + LEN_CMP_W'(len_upd))
            status = STATUS_MALFORMED;
        else if (crc_upd != hcrc_upd)
            status = STATUS_CRC_ERROR;
        else
            status = STATUS_OK;
    end

    always_comb
    begin
        push_item.has_payload             = in_payload;
        push_item.has_summary             = in_data.last_byte;
        push_item.payload_byte            = b;
        push_item.summary.status          = status;
        push_item.summary.version_seen    = ver_upd;
        push_item.summary.topic           = topic_upd;
        push_item.summary.time_stamp      = time_upd;
        push_item.summary.seq_number      = seq_upd;
        push_item.summary.declared_length = len_upd;
        push_item.summary.carried_crc     = hcrc_upd;
    end

    assign push = accept && (in_payload || in_data.last_byte);

    always_comb
    begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        sync_next    = sync_reg;
        overrun_next = overrun_reg;
        ver_next     = ver_reg;
        topic_next   = topic_reg;
        time_next    = time_reg;
        seq_next     = seq_reg;
        len_next     = len_reg;
        hcrc_next    = hcrc_reg;
        exp_ver_next = cfg_wr_en ? cfg_wr_data : exp_ver_reg;
        if (accept)
        begin
            if (in_data.last_byte)
            begin
                pos_next     = '0;
                crc_next     = CRC_INIT;
                sync_next    = 1'b0;
                overrun_next = 1'b0;
                ver_next     = '0;
                topic_next   = '0;
                time_next    = '0;
                seq_next     = '0;
                len_next     = '0;
                hcrc_next    = '0;
            end
            else
            begin
                pos_next     = pos_upd;
                crc_next     = crc_upd;
                sync_next    = sync_upd;
                overrun_next = overrun_upd;
                ver_next     = ver_upd;
                topic_next   = topic_upd;
                time_next    = time_upd;
                seq_next     = seq_upd;
                len_next     = len_upd;
                hcrc_next    = hcrc_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            crc_reg     <= CRC_INIT;
            sync_reg    <= 1'b0;
            overrun_reg <= 1'b0;
            ver_reg     <= '0;
            topic_reg   <= '0;
            time_reg    <= '0;
            seq_reg     <= '0;
            len_reg     <= '0;
            hcrc_reg    <= '0;
            exp_ver_reg <= VERSION_INIT;
        end
        else
        begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            sync_reg    <= sync_next;
            overrun_reg <= overrun_next;
            ver_reg     <= ver_next;
            topic_reg   <= topic_next;
            time_reg    <= time_next;
            seq_reg     <= seq_next;
            len_reg     <= len_next;
            hcrc_reg    <= hcrc_next;
            exp_ver_reg <= exp_ver_next;
        end
    end

endmodule

### rtl/tfc_queue.sv
// ----------------------------------------------------------------------------
// tfc_queue
// small fifo of pending records between the front and back parts
// ----------------------------------------------------------------------------
module tfc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tfc_pkg::queue_item_t push_item,
    input  logic                 pop,
    output tfc_pkg::queue_item_t head,
    output logic                 full,
    output logic                 empty
);
    import tfc_pkg::*;

    queue_item_t         slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = count_reg == QUEUE_CW'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QUEUE_CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QUEUE_CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/tfc_back.sv
// ----------------------------------------------------------------------------
// tfc_back
// drains queued records into payload and summary transactions
// ----------------------------------------------------------------------------
module tfc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tfc_pkg::queue_item_t head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output tfc_pkg::out_item_t   out_data
);
    import tfc_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t item_reg, item_next;
    logic      split_reg, split_next;
    logic      load;

    assign out_valid = valid_reg;
    assign out_data  = item_reg;
    assign load      = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        split_next = split_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                if (head.has_payload && !split_reg)
                begin
                    item_next              = '0;
                    item_next.payload_byte = head.payload_byte;
                    item_next.status       = STATUS_OK;
                    if (head.has_summary)
                        split_next = 1'b1;
                    else
                        pop = 1'b1;
                end
                else
                begin
                    item_next.is_summary      = 1'b1;
                    item_next.payload_byte    = '0;
                    item_next.status          = head.summary.status;
                    item_next.version_seen    = head.summary.version_seen;
                    item_next.topic           = head.summary.topic;
                    item_next.time_stamp      = head.summary.time_stamp;
                    item_next.seq_number      = head.summary.seq_number;
                    item_next.declared_length = head.summary.declared_length;
                    item_next.carried_crc     = head.summary.carried_crc;
                    split_next                = 1'b0;
                    pop                       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            split_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            split_reg <= split_next;
        end
    end

endmodule
